// ===== src/budgeted_nearest_entity_select_unit_defines.svh =====
// Assertion macros used by the back end RTL of the nearest entity select unit.
`ifndef BUDGETED_NEAREST_ENTITY_SELECT_UNIT_DEFINES_SVH
`define BUDGETED_NEAREST_ENTITY_SELECT_UNIT_DEFINES_SVH
`ifndef SYNTHESIS
`define BNES_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("assertion failed");
`define BNES_ASSERT_ALWAYS(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) prop) else $error("assertion failed");
`else
`define BNES_ASSERT(lbl, clk, rst_n, prop)
`define BNES_ASSERT_ALWAYS(lbl, clk, prop)
`endif
`endif

// ===== src/bnes_pkg.sv =====
// Types and constants of the nearest entity select unit.
package bnes_pkg;
  localparam int STORE_DEPTH_DEF = 256;
  localparam int MAX_SELECT_DEF  = 64;
  localparam int DIST_W = 52;

  localparam logic [1:0] OP_START  = 2'd0;
  localparam logic [1:0] OP_ENTITY = 2'd1;
  localparam logic [1:0] OP_FINISH = 2'd2;

  localparam logic [1:0] REG_RADIUS   = 2'd0;
  localparam logic [1:0] REG_BUDGET   = 2'd1;
  localparam logic [1:0] REG_CAPACITY = 2'd2;

  typedef enum logic [1:0] {
    CMD_START,
    CMD_ENTITY,
    CMD_FINISH
  } cmd_kind_t;

  typedef struct packed {
    logic [1:0]         opcode;
    logic signed [23:0] coord_x;
    logic signed [23:0] coord_y;
    logic signed [23:0] coord_z;
    logic               dirty;
    logic [15:0]        ident;
    logic [15:0]        object_bytes;
  } in_item_t;

  typedef struct packed {
    logic        present;
    logic [15:0] selected_id;
    logic [6:0]  selected_count;
    logic [23:0] running_bytes;
    logic        last;
  } out_item_t;

  typedef struct packed {
    logic [DIST_W-1:0] range_sq;
    logic [15:0]       ident;
    logic [15:0]       nbytes;
  } entry_t;

  typedef struct packed {
    cmd_kind_t kind;
    entry_t    ent;
  } cmd_t;
endpackage

// ===== src/bnes_ram.sv =====
// Generic single write, single read RAM with registered read data.
module bnes_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;
endmodule

// ===== src/bnes_fifo.sv =====
// Two-entry flop queue.
module bnes_fifo #(
  parameter int WIDTH = 8
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  logic [WIDTH-1:0] wdata,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] rdata,
  output logic             empty
);
  logic [WIDTH-1:0] mem_r [2];
  logic             wptr_r;
  logic             rptr_r;
  logic [1:0]       cnt_r;
  logic             do_push;
  logic             do_pop;

  assign full    = (cnt_r == 2'd2);
  assign empty   = (cnt_r == 2'd0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rdata   = mem_r[rptr_r];

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wptr_r] <= wdata;
    end
    if (!rst_n) begin
      wptr_r <= 1'b0;
      rptr_r <= 1'b0;
      cnt_r  <= 2'd0;
    end else begin
      if (do_push) begin
        wptr_r <= !wptr_r;
      end
      if (do_pop) begin
        rptr_r <= !rptr_r;
      end
      cnt_r <= cnt_r + {1'b0, do_push} - {1'b0, do_pop};
    end
  end
endmodule

// ===== src/bnes_front.sv =====
// Front end: takes items, holds the viewpoint, measures and filters entities.
module bnes_front (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_push,
  output logic              in_full,
  input  bnes_pkg::in_item_t in_item,
  input  logic [23:0]       radius,
  output logic              cmd_push,
  output bnes_pkg::cmd_t    cmd_data,
  input  logic              cmd_full
);
  typedef enum logic [2:0] {
    S_IDLE, S_SQX, S_SQY, S_SQZ, S_SQR, S_CMP
  } state_t;

  state_t state_r;
  logic signed [23:0] view_x_r, view_y_r, view_z_r;
  logic [24:0] dx_r, dy_r, dz_r;
  logic [49:0] prod_r;
  logic [bnes_pkg::DIST_W-1:0] acc_r;
  logic        dirty_r;
  logic [15:0] ident_r, bytes_r;
  logic        accept;
  logic [24:0] mul_a;
  logic [24:0] mag_x, mag_y, mag_z;

  function automatic logic [24:0] mag(input logic signed [23:0] a,
                                      input logic signed [23:0] b);
    logic signed [24:0] d;
    d = 25'(a) - 25'(b);
    return d[24] ? 25'(-d) : 25'(d);
  endfunction

  assign in_full = (state_r != S_IDLE) || cmd_full;
  assign accept  = in_push && !in_full;
  assign mag_x   = mag(in_item.coord_x, view_x_r);
  assign mag_y   = mag(in_item.coord_y, view_y_r);
  assign mag_z   = mag(in_item.coord_z, view_z_r);

  always_comb begin
    unique case (state_r)
      S_SQX:   mul_a = dx_r;
      S_SQY:   mul_a = dy_r;
      S_SQZ:   mul_a = dz_r;
      default: mul_a = {1'b0, radius};
    endcase
  end

  always_comb begin
    cmd_push = 1'b0;
    cmd_data.kind = bnes_pkg::CMD_START;
    cmd_data.ent.range_sq = acc_r;
    cmd_data.ent.ident = ident_r;
    cmd_data.ent.nbytes = bytes_r;
    if (state_r == S_IDLE) begin
      if (accept && in_item.opcode == bnes_pkg::OP_START) begin
        cmd_push = 1'b1;
      end else if (accept && in_item.opcode == bnes_pkg::OP_FINISH) begin
        cmd_push = 1'b1;
        cmd_data.kind = bnes_pkg::CMD_FINISH;
      end
    end else if (state_r == S_CMP) begin
      cmd_data.kind = bnes_pkg::CMD_ENTITY;
      cmd_push = dirty_r && (acc_r <= bnes_pkg::DIST_W'(prod_r)) && !cmd_full;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      view_x_r <= '0;
      view_y_r <= '0;
      view_z_r <= '0;
    end else begin
      unique case (state_r)
        S_IDLE: begin
          if (accept && in_item.opcode == bnes_pkg::OP_START) begin
            view_x_r <= in_item.coord_x;
            view_y_r <= in_item.coord_y;
            view_z_r <= in_item.coord_z;
          end else if (accept && in_item.opcode == bnes_pkg::OP_ENTITY) begin
            dx_r    <= mag_x;
            dy_r    <= mag_y;
            dz_r    <= mag_z;
            dirty_r <= in_item.dirty;
            ident_r <= in_item.ident;
            bytes_r <= in_item.object_bytes;
            state_r <= S_SQX;
          end
        end
        S_SQX: begin
          prod_r  <= mul_a * mul_a;
          state_r <= S_SQY;
        end
        S_SQY: begin
          acc_r   <= bnes_pkg::DIST_W'(prod_r);
          prod_r  <= mul_a * mul_a;
          state_r <= S_SQZ;
        end
        S_SQZ: begin
          acc_r   <= acc_r + bnes_pkg::DIST_W'(prod_r);
          prod_r  <= mul_a * mul_a;
          state_r <= S_SQR;
        end
        S_SQR: begin
          acc_r   <= acc_r + bnes_pkg::DIST_W'(prod_r);
          prod_r  <= mul_a * mul_a;
          state_r <= S_CMP;
        end
        S_CMP: begin
          if (!(dirty_r && (acc_r <= bnes_pkg::DIST_W'(prod_r))) || !cmd_full) begin
            state_r <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end
endmodule

// ===== src/bnes_back.sv =====
// Back end: sorted candidate store maintenance and budgeted emission.
`include "budgeted_nearest_entity_select_unit_defines.svh"
module bnes_back #(
  parameter int STORE_DEPTH = bnes_pkg::STORE_DEPTH_DEF,
  parameter int MAX_SELECT  = bnes_pkg::MAX_SELECT_DEF,
  localparam int AW = $clog2(STORE_DEPTH),
  localparam int CW = $clog2(STORE_DEPTH + 1)
) (
  input  logic                clk,
  input  logic                rst_n,
  input  bnes_pkg::cmd_t      cmd_data,
  input  logic                cmd_empty,
  output logic                cmd_pop,
  input  logic [23:0]         byte_budget,
  input  logic [6:0]          result_capacity,
  output logic                ram_we,
  output logic [AW-1:0]       ram_waddr,
  output bnes_pkg::entry_t    ram_wdata,
  output logic                ram_re,
  output logic [AW-1:0]       ram_raddr,
  input  bnes_pkg::entry_t    ram_rdata,
  output logic                out_push,
  output bnes_pkg::out_item_t out_data,
  input  logic                out_full
);
  typedef enum logic [2:0] {
    S_IDLE, S_INS, S_INS_WR, S_FIN, S_FIN_END
  } state_t;

  state_t state_r, state_nxt;
  logic [CW-1:0] count_r, count_nxt;
  bnes_pkg::entry_t key_r, key_nxt;
  logic [AW-1:0] k_r, k_nxt, i_r, i_nxt;
  logic chk_r, chk_nxt, grow_r, grow_nxt;
  logic [6:0] n_r, n_nxt, cap_r, cap_nxt, cap_c;
  logic [23:0] used_r, used_nxt;
  bnes_pkg::out_item_t pend_r, pend_nxt;
  logic pend_v_r, pend_v_nxt;
  logic after;
  logic [24:0] sum;

  assign cap_c = (result_capacity > 7'(MAX_SELECT)) ? 7'(MAX_SELECT) : result_capacity;
  assign after = (ram_rdata.range_sq > key_r.range_sq) ||
                 ((ram_rdata.range_sq == key_r.range_sq) &&
                  (ram_rdata.ident > key_r.ident));
  assign sum = {1'b0, used_r} + 25'(ram_rdata.nbytes);

  always_comb begin
    state_nxt = state_r; count_nxt = count_r; key_nxt = key_r;
    k_nxt = k_r; i_nxt = i_r; chk_nxt = chk_r; grow_nxt = grow_r;
    n_nxt = n_r; cap_nxt = cap_r; used_nxt = used_r;
    pend_nxt = pend_r; pend_v_nxt = pend_v_r;
    cmd_pop = 1'b0;
    ram_we = 1'b0; ram_waddr = k_r; ram_wdata = key_r;
    ram_re = 1'b0; ram_raddr = '0;
    out_push = 1'b0; out_data = pend_r;
    unique case (state_r)
      S_IDLE: begin
        if (!cmd_empty) begin
          cmd_pop = 1'b1;
          unique case (cmd_data.kind)
            bnes_pkg::CMD_START: count_nxt = '0;
            bnes_pkg::CMD_ENTITY: begin
              key_nxt = cmd_data.ent;
              if (count_r == CW'(STORE_DEPTH)) begin
                ram_re = 1'b1;
                ram_raddr = AW'(STORE_DEPTH - 1);
                k_nxt = AW'(STORE_DEPTH - 1);
                chk_nxt = 1'b1;
                grow_nxt = 1'b0;
                state_nxt = S_INS;
              end else if (count_r == '0) begin
                ram_we = 1'b1;
                ram_waddr = '0;
                ram_wdata = cmd_data.ent;
                count_nxt = CW'(1);
              end else begin
                ram_re = 1'b1;
                ram_raddr = AW'(count_r - CW'(1));
                k_nxt = AW'(count_r);
                chk_nxt = 1'b0;
                grow_nxt = 1'b1;
                state_nxt = S_INS;
              end
            end
            bnes_pkg::CMD_FINISH: begin
              cap_nxt = cap_c;
              n_nxt = '0;
              used_nxt = '0;
              i_nxt = '0;
              pend_v_nxt = 1'b0;
              if (count_r == '0 || cap_c == '0) begin
                state_nxt = S_FIN_END;
              end else begin
                ram_re = 1'b1;
                ram_raddr = '0;
                state_nxt = S_FIN;
              end
            end
            default: ;
          endcase
        end
      end
      S_INS: begin
        if (chk_r) begin
          if (!after) begin
            state_nxt = S_IDLE;
          end else begin
            chk_nxt = 1'b0;
            ram_re = 1'b1;
            ram_raddr = k_r - AW'(1);
          end
        end else if (after) begin
          ram_we = 1'b1;
          ram_wdata = ram_rdata;
          k_nxt = k_r - AW'(1);
          if (k_r == AW'(1)) begin
            state_nxt = S_INS_WR;
          end else begin
            ram_re = 1'b1;
            ram_raddr = k_r - AW'(2);
          end
        end else begin
          ram_we = 1'b1;
          if (grow_r) count_nxt = count_r + CW'(1);
          state_nxt = S_IDLE;
        end
      end
      S_INS_WR: begin
        ram_we = 1'b1;
        if (grow_r) count_nxt = count_r + CW'(1);
        state_nxt = S_IDLE;
      end
      S_FIN: begin
        if (sum > {1'b0, byte_budget}) begin
          state_nxt = S_FIN_END;
        end else if (!(pend_v_r && out_full)) begin
          out_push = pend_v_r;
          out_data.last = 1'b0;
          pend_nxt.present = 1'b1;
          pend_nxt.selected_id = ram_rdata.ident;
          pend_nxt.selected_count = n_r + 7'd1;
          pend_nxt.running_bytes = sum[23:0];
          pend_nxt.last = 1'b0;
          pend_v_nxt = 1'b1;
          n_nxt = n_r + 7'd1;
          used_nxt = sum[23:0];
          i_nxt = i_r + AW'(1);
          if ((n_r + 7'd1 == cap_r) || (CW'(i_r) + CW'(1) == count_r)) begin
            state_nxt = S_FIN_END;
          end else begin
            ram_re = 1'b1;
            ram_raddr = i_r + AW'(1);
          end
        end
      end
      S_FIN_END: begin
        if (!out_full) begin
          out_push = 1'b1;
          if (!pend_v_r) out_data = '0;
          out_data.last = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    key_r <= key_nxt; k_r <= k_nxt; i_r <= i_nxt;
    chk_r <= chk_nxt; grow_r <= grow_nxt; n_r <= n_nxt; cap_r <= cap_nxt;
    used_r <= used_nxt; pend_r <= pend_nxt;
    if (!rst_n) begin
      state_r  <= S_IDLE;
      count_r  <= '0;
      pend_v_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      count_r  <= count_nxt;
      pend_v_r <= pend_v_nxt;
    end
  end

  `BNES_ASSERT(a_count_bound, clk, rst_n, count_r <= CW'(STORE_DEPTH))
  `BNES_ASSERT(a_pop_idle, clk, rst_n, cmd_pop |-> (state_r == S_IDLE))
  `BNES_ASSERT(a_push_room, clk, rst_n, out_push |-> !out_full)
  `BNES_ASSERT(a_last_ends, clk, rst_n, (out_push && out_data.last) |=> (state_r == S_IDLE))
endmodule

// ===== src/budgeted_nearest_entity_select_unit.sv =====
// Top level of the budgeted nearest entity select unit.
// Channels: input items enter as a queue (in_push / in_full); results leave as
// a queue (out_pop / out_empty), oldest result on out_item while out_empty is
// low. Configuration registers are written over cfg_valid / cfg_ready, with
// cfg_ready always high; write only while the block is idle.
// Start: the viewpoint is taken at once and the store is cleared.
// Entity: the front measures it with one shared 25x25 multiplier that forms
// three squares and radius squared in turn; the back then inserts into the
// sorted store walking it one entry per cycle from the tail, through the
// single read port of the store RAM.
// Finish: one store read per selected id, plus one more when the byte budget
// stops the walk.
// A short command queue decouples front and back, so the front measures the
// next entity while the back inserts the previous one.
// Reset clears the viewpoint, the entry count and the queues; no store sweep
// is needed. If the receiver stalls, the two-entry result queue fills and the
// back end holds its walk until a transfer frees a slot.
module budgeted_nearest_entity_select_unit #(
  parameter int STORE_DEPTH = bnes_pkg::STORE_DEPTH_DEF,
  parameter int MAX_SELECT  = bnes_pkg::MAX_SELECT_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_push,
  output logic                in_full,
  input  bnes_pkg::in_item_t  in_item,
  output logic                out_empty,
  input  logic                out_pop,
  output bnes_pkg::out_item_t out_item,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [1:0]          cfg_index,
  input  logic [23:0]         cfg_data
);
  localparam int AW = $clog2(STORE_DEPTH);

  logic [23:0] radius_r, budget_r;
  logic [6:0]  capacity_r;
  logic cmd_push, cmd_full, cmd_empty, cmd_pop;
  bnes_pkg::cmd_t cmd_wdata, cmd_rdata;
  logic ram_we, ram_re;
  logic [AW-1:0] ram_waddr, ram_raddr;
  bnes_pkg::entry_t ram_wdata, ram_rdata;
  logic res_push, res_full;
  bnes_pkg::out_item_t res_data;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      radius_r   <= '0;
      budget_r   <= '0;
      capacity_r <= 7'(bnes_pkg::MAX_SELECT_DEF);
    end else if (cfg_valid) begin
      unique case (cfg_index)
        bnes_pkg::REG_RADIUS:   radius_r <= cfg_data;
        bnes_pkg::REG_BUDGET:   budget_r <= cfg_data;
        bnes_pkg::REG_CAPACITY: capacity_r <= cfg_data[6:0];
        default: ;
      endcase
    end
  end

  bnes_front u_front (
    .clk(clk), .rst_n(rst_n), .in_push(in_push), .in_full(in_full),
    .in_item(in_item), .radius(radius_r), .cmd_push(cmd_push),
    .cmd_data(cmd_wdata), .cmd_full(cmd_full)
  );

  bnes_fifo #(.WIDTH($bits(bnes_pkg::cmd_t))) u_cmd_q (
    .clk(clk), .rst_n(rst_n), .push(cmd_push), .wdata(cmd_wdata),
    .full(cmd_full), .pop(cmd_pop), .rdata(cmd_rdata), .empty(cmd_empty)
  );

  bnes_ram #(.WIDTH($bits(bnes_pkg::entry_t)), .DEPTH(STORE_DEPTH)) u_store (
    .clk(clk), .we(ram_we), .waddr(ram_waddr), .wdata(ram_wdata),
    .re(ram_re), .raddr(ram_raddr), .rdata(ram_rdata)
  );

  bnes_back #(.STORE_DEPTH(STORE_DEPTH), .MAX_SELECT(MAX_SELECT)) u_back (
    .clk(clk), .rst_n(rst_n), .cmd_data(cmd_rdata), .cmd_empty(cmd_empty),
    .cmd_pop(cmd_pop), .byte_budget(budget_r), .result_capacity(capacity_r),
    .ram_we(ram_we), .ram_waddr(ram_waddr), .ram_wdata(ram_wdata),
    .ram_re(ram_re), .ram_raddr(ram_raddr), .ram_rdata(ram_rdata),
    .out_push(res_push), .out_data(res_data), .out_full(res_full)
  );

  bnes_fifo #(.WIDTH($bits(bnes_pkg::out_item_t))) u_res_q (
    .clk(clk), .rst_n(rst_n), .push(res_push), .wdata(res_data),
    .full(res_full), .pop(out_pop), .rdata(out_item), .empty(out_empty)
  );
endmodule

// ===== dv/budgeted_nearest_entity_select_unit_tb.sv =====
// Testbench of the nearest entity select unit: directed table, then random queries.
module budgeted_nearest_entity_select_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [1:0] OP_IGNORED = 2'd3;
  localparam int DEPTH = bnes_pkg::STORE_DEPTH_DEF;
  localparam int SEL_MAX = bnes_pkg::MAX_SELECT_DEF;
  localparam int DRAIN_CYCLES = 300;
  localparam longint CYCLE_LIMIT = 4000000;
  localparam int RAND_ITEMS = 500;

  typedef enum logic [1:0] {ROW_ITEM, ROW_TYPED, ROW_CFG} row_kind_t;
  typedef struct {
    row_kind_t           kind;
    bnes_pkg::in_item_t  item;
    bnes_pkg::out_item_t result;
    logic [1:0]          index;
    logic [23:0]         data;
  } script_row_t;

  logic                clk;
  logic                rst_n;
  logic                in_push;
  logic                in_full;
  bnes_pkg::in_item_t  in_item;
  logic                out_empty;
  logic                out_pop;
  bnes_pkg::out_item_t out_item;
  logic                cfg_valid;
  logic                cfg_ready;
  logic [1:0]          cfg_index;
  logic [23:0]         cfg_data;

  budgeted_nearest_entity_select_unit u_dut (
    .clk(clk), .rst_n(rst_n),
    .in_push(in_push), .in_full(in_full), .in_item(in_item),
    .out_empty(out_empty), .out_pop(out_pop), .out_item(out_item),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  // selection state
  longint unsigned sel_radius, sel_budget, sel_capacity;
  longint          view_x, view_y, view_z;
  longint unsigned cand_dist[DEPTH];
  logic [15:0]     cand_id[DEPTH];
  logic [15:0]     cand_nbytes[DEPTH];
  int              cand_cnt;

  bnes_pkg::out_item_t fresh_q[$];
  bnes_pkg::out_item_t selection_q[$];
  script_row_t         script_q[$];

  int     mismatches;
  int     checked;
  int     rand_items;
  int     finishes;
  int     overflow_hits;
  longint cycles;
  bit     quiet;
  bit     hold_req;
  int     hold_left;
  int     gap_left;

  initial clk = 1'b0;
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  function automatic void reset_selection();
    sel_radius = 0;
    sel_budget = 0;
    sel_capacity = 64;
    view_x = 0;
    view_y = 0;
    view_z = 0;
    cand_cnt = 0;
  endfunction

  function automatic void store_candidate(longint unsigned d, logic [15:0] id, logic [15:0] nb);
    int p;
    p = 0;
    while (p < cand_cnt &&
           !(cand_dist[p] != d ? cand_dist[p] > d : cand_id[p] > id)) p++;
    if (cand_cnt >= DEPTH) begin
      overflow_hits++;
      if (p >= cand_cnt) return;
      cand_cnt = DEPTH - 1;
    end
    for (int k = cand_cnt; k > p; k--) begin
      cand_dist[k] = cand_dist[k-1];
      cand_id[k] = cand_id[k-1];
      cand_nbytes[k] = cand_nbytes[k-1];
    end
    cand_dist[p] = d;
    cand_id[p] = id;
    cand_nbytes[p] = nb;
    cand_cnt++;
  endfunction

  // results of one item go to fresh_q
  function automatic void predict_selection(bnes_pkg::in_item_t it);
    longint dx, dy, dz;
    longint unsigned d, cap, used;
    int n;
    bnes_pkg::out_item_t r;
    fresh_q.delete();
    case (it.opcode)
      bnes_pkg::OP_START: begin
        view_x = longint'($signed(it.coord_x));
        view_y = longint'($signed(it.coord_y));
        view_z = longint'($signed(it.coord_z));
        cand_cnt = 0;
      end
      bnes_pkg::OP_ENTITY: begin
        dx = longint'($signed(it.coord_x)) - view_x;
        dy = longint'($signed(it.coord_y)) - view_y;
        dz = longint'($signed(it.coord_z)) - view_z;
        d = dx * dx + dy * dy + dz * dz;
        if (it.dirty && d <= sel_radius * sel_radius)
          store_candidate(d, it.ident, it.object_bytes);
      end
      bnes_pkg::OP_FINISH: begin
        cap = (sel_capacity > SEL_MAX) ? SEL_MAX : sel_capacity;
        used = 0;
        n = 0;
        for (int i = 0; i < cand_cnt; i++) begin
          if (n >= cap || used + cand_nbytes[i] > sel_budget) break;
          used += cand_nbytes[i];
          n++;
          r.present = 1'b1;
          r.selected_id = cand_id[i];
          r.selected_count = 7'(n);
          r.running_bytes = 24'(used);
          r.last = 1'b0;
          fresh_q.push_back(r);
        end
        if (n == 0) fresh_q.push_back({1'b0, 16'd0, 7'd0, 24'd0, 1'b1});
        else fresh_q[n-1].last = 1'b1;
        finishes++;
      end
      default: ;
    endcase
  endfunction

  // result checker
  always @(posedge clk) begin
    bnes_pkg::out_item_t want;
    if (rst_n && out_pop && !out_empty) begin
      if (selection_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result %h", out_item);
      end else begin
        want = selection_q.pop_front();
        checked++;
        if (out_item.present !== want.present ||
            out_item.selected_id !== want.selected_id ||
            out_item.selected_count !== want.selected_count ||
            out_item.running_bytes !== want.running_bytes ||
            out_item.last !== want.last) begin
          mismatches++;
          if (mismatches <= 10)
            $display("result mismatch: exp p=%b id=%h n=%0d bytes=%0d last=%b,",
                     want.present, want.selected_id, want.selected_count,
                     want.running_bytes, want.last,
                     " got p=%b id=%h n=%0d bytes=%0d last=%b",
                     out_item.present, out_item.selected_id, out_item.selected_count,
                     out_item.running_bytes, out_item.last);
        end
      end
    end
  end

  // receiver: random stall bursts plus one long hold-off
  always @(negedge clk) begin
    if (!rst_n) out_pop <= 1'b0;
    else if (hold_req) begin
      hold_req = 1'b0;
      hold_left = 1500;
      out_pop <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left--;
      out_pop <= 1'b0;
    end else if (gap_left > 0) begin
      gap_left--;
      out_pop <= 1'b0;
    end else if (!quiet && $urandom_range(0, 5) == 0) begin
      gap_left = $urandom_range(1, 13) - 1;
      out_pop <= 1'b0;
    end else out_pop <= 1'b1;
  end

  // called at a falling edge, returns at a falling edge
  task automatic send_item(bnes_pkg::in_item_t it, bit typed, bnes_pkg::out_item_t result);
    bit ok;
    if (!quiet && $urandom_range(0, 4) == 0) begin
      in_push <= 1'b0;
      repeat ($urandom_range(1, 13)) @(negedge clk);
    end
    in_push <= 1'b1;
    in_item <= it;
    do begin
      @(posedge clk);
      ok = !in_full;
      @(negedge clk);
    end while (!ok);
    predict_selection(it);
    if (typed) selection_q.push_back(result);
    else foreach (fresh_q[i]) selection_q.push_back(fresh_q[i]);
  endtask

  task automatic settle();
    in_push <= 1'b0;
    while (selection_q.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [23:0] value);
    bit ok;
    settle();
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    do begin
      @(posedge clk);
      ok = cfg_ready;
      @(negedge clk);
    end while (!ok);
    cfg_valid <= 1'b0;
    case (idx)
      bnes_pkg::REG_RADIUS:   sel_radius = value;
      bnes_pkg::REG_BUDGET:   sel_budget = value;
      bnes_pkg::REG_CAPACITY: sel_capacity = value[6:0];
      default: ;
    endcase
  endtask

  function automatic bnes_pkg::in_item_t make_item(logic [1:0] op, logic [23:0] x,
                                                   logic [23:0] y, logic [23:0] z,
                                                   logic d, logic [15:0] id,
                                                   logic [15:0] nb);
    bnes_pkg::in_item_t it;
    it.opcode = op;
    it.coord_x = x;
    it.coord_y = y;
    it.coord_z = z;
    it.dirty = d;
    it.ident = id;
    it.object_bytes = nb;
    return it;
  endfunction

  function automatic void add_row(row_kind_t k, bnes_pkg::in_item_t it,
                                  bnes_pkg::out_item_t r,
                                  logic [1:0] idx, logic [23:0] value);
    script_row_t row;
    row.kind = k;
    row.item = it;
    row.result = r;
    row.index = idx;
    row.data = value;
    script_q.push_back(row);
  endfunction

  function automatic logic [23:0] near_coord(longint c, longint unsigned span);
    longint off;
    off = longint'($urandom_range(0, 32'(2 * span))) - longint'(span);
    return 24'(c + off);
  endfunction

  task automatic random_query(int n_ent, bit big);
    bnes_pkg::in_item_t it, prev;
    longint unsigned span;
    logic [15:0] nb;
    it = make_item(bnes_pkg::OP_START, 24'($urandom), 24'($urandom), 24'($urandom),
                   1'($urandom), 16'($urandom), 16'($urandom));
    if (big || $urandom_range(0, 2) == 0) begin
      it.coord_x = 24'($urandom_range(0, 4095));
      it.coord_y = 24'($urandom_range(0, 4095));
      it.coord_z = 24'($urandom_range(0, 4095));
    end
    send_item(it, 1'b0, '0);
    rand_items++;
    prev = it;
    span = (sel_radius >> 1) + 4;
    if (span > 32'h3FFF_FFFF) span = 32'h3FFF_FFFF;
    for (int e = 0; e < n_ent; e++) begin
      nb = ($urandom_range(0, 3) == 0) ? 16'($urandom) : 16'($urandom_range(0, 300));
      if (!big && $urandom_range(0, 12) == 0)
        it = make_item(OP_IGNORED, 24'($urandom), 24'($urandom), 24'($urandom),
                       1'($urandom), 16'($urandom), 16'($urandom));
      else if (!big && $urandom_range(0, 9) == 0)
        it = make_item(bnes_pkg::OP_ENTITY, 24'($urandom), 24'($urandom), 24'($urandom),
                       1'($urandom), 16'($urandom), nb);
      else begin
        it = make_item(bnes_pkg::OP_ENTITY, near_coord(view_x, span),
                       near_coord(view_y, span), near_coord(view_z, span),
                       big || $urandom_range(0, 6) != 0,
                       ($urandom_range(0, 2) == 0) ? 16'($urandom_range(0, 7)) : 16'($urandom),
                       nb);
        if ($urandom_range(0, 5) == 0) begin
          it.coord_x = (prev.opcode == bnes_pkg::OP_ENTITY) ? prev.coord_x : 24'(view_x);
          it.coord_y = (prev.opcode == bnes_pkg::OP_ENTITY) ? prev.coord_y : 24'(view_y);
          it.coord_z = (prev.opcode == bnes_pkg::OP_ENTITY) ? prev.coord_z : 24'(view_z);
        end
      end
      send_item(it, 1'b0, '0);
      if (it.opcode != OP_IGNORED) rand_items++;
      prev = it;
    end
    // long receiver hold-off while the full selection drains
    if (big) hold_req = 1'b1;
    repeat ($urandom_range(1, 2)) begin
      send_item(make_item(bnes_pkg::OP_FINISH, 24'($urandom), 24'($urandom), 24'($urandom),
                          1'($urandom), 16'($urandom), 16'($urandom)), 1'b0, '0);
      rand_items++;
    end
  endtask

  initial begin
    bnes_pkg::in_item_t z_it;
    int phase;
    logic [23:0] value;
    rst_n = 1'b0;
    in_push = 1'b0;
    in_item = '0;
    out_pop = 1'b0;
    cfg_valid = 1'b0;
    cfg_index = bnes_pkg::REG_RADIUS;
    cfg_data = '0;
    mismatches = 0;
    checked = 0;
    rand_items = 0;
    finishes = 0;
    overflow_hits = 0;
    cycles = 0;
    quiet = 1'b0;
    hold_req = 1'b0;
    hold_left = 0;
    gap_left = 0;
    reset_selection();
    repeat (8) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    z_it = '0;
    add_row(ROW_ITEM, make_item(OP_IGNORED, '1, '1, '1, 1'b1, '1, '1), '0, 0, 0);
    add_row(ROW_TYPED, make_item(bnes_pkg::OP_FINISH, 0, 0, 0, 0, 0, 0),
            {1'b0, 16'd0, 7'd0, 24'd0, 1'b1}, 0, 0);
    add_row(ROW_ITEM, make_item(bnes_pkg::OP_ENTITY, 0, 0, 0, 1'b1, 16'hABCD, 0), '0, 0, 0);
    add_row(ROW_ITEM, make_item(bnes_pkg::OP_ENTITY, 0, 0, 0, 1'b0, 16'h1234, 0), '0, 0, 0);
    add_row(ROW_TYPED, make_item(bnes_pkg::OP_FINISH, 0, 0, 0, 0, 0, 0),
            {1'b1, 16'hABCD, 7'd1, 24'd0, 1'b1}, 0, 0);
    add_row(ROW_CFG, z_it, '0, bnes_pkg::REG_RADIUS, 24'hFFFFFF);
    add_row(ROW_CFG, z_it, '0, bnes_pkg::REG_BUDGET, 24'hFFFFFF);
    add_row(ROW_CFG, z_it, '0, bnes_pkg::REG_CAPACITY, 24'd127);
    add_row(ROW_ITEM, make_item(bnes_pkg::OP_START, 24'h800000, 24'h800000, 24'h800000,
                                0, 0, 0), '0, 0, 0);
    add_row(ROW_ITEM, make_item(bnes_pkg::OP_ENTITY, 24'h7FFFFF, 24'h7FFFFF, 24'h7FFFFF, 1'b1,
                                16'hFFFF, 16'hFFFF), '0, 0, 0);
    add_row(ROW_ITEM, make_item(bnes_pkg::OP_ENTITY, 24'h7FFFFF, 24'h800000, 24'h800000, 1'b1,
                                16'h0009, 16'h0010), '0, 0, 0);
    add_row(ROW_ITEM, make_item(bnes_pkg::OP_ENTITY, 24'h800000, 24'h800000, 24'h800000, 1'b1,
                                16'h0000, 16'hFFFF), '0, 0, 0);
    add_row(ROW_ITEM, make_item(bnes_pkg::OP_ENTITY, 24'h800000, 24'h800000, 24'h800000, 1'b1,
                                16'h0000, 16'h0001), '0, 0, 0);
    add_row(ROW_ITEM, make_item(bnes_pkg::OP_ENTITY, 24'h800000, 24'h800000, 24'h800000, 1'b1,
                                16'h0005, 16'h0002), '0, 0, 0);
    add_row(ROW_ITEM, make_item(bnes_pkg::OP_FINISH, 0, 0, 0, 0, 0, 0), '0, 0, 0);
    add_row(ROW_ITEM, make_item(bnes_pkg::OP_FINISH, '1, '1, '1, 1'b1, '1, '1), '0, 0, 0);
    add_row(ROW_CFG, z_it, '0, bnes_pkg::REG_CAPACITY, 24'd1);
    add_row(ROW_ITEM, make_item(bnes_pkg::OP_FINISH, 0, 0, 0, 0, 0, 0), '0, 0, 0);
    add_row(ROW_CFG, z_it, '0, bnes_pkg::REG_CAPACITY, 24'd0);
    add_row(ROW_TYPED, make_item(bnes_pkg::OP_FINISH, 0, 0, 0, 0, 0, 0),
            {1'b0, 16'd0, 7'd0, 24'd0, 1'b1}, 0, 0);
    add_row(ROW_CFG, z_it, '0, bnes_pkg::REG_CAPACITY, 24'd64);
    add_row(ROW_CFG, z_it, '0, bnes_pkg::REG_BUDGET, 24'd0);
    add_row(ROW_TYPED, make_item(bnes_pkg::OP_FINISH, 0, 0, 0, 0, 0, 0),
            {1'b0, 16'd0, 7'd0, 24'd0, 1'b1}, 0, 0);
    add_row(ROW_CFG, z_it, '0, bnes_pkg::REG_RADIUS, 24'd0);

    foreach (script_q[i]) begin
      if (script_q[i].kind == ROW_CFG) write_reg(script_q[i].index, script_q[i].data);
      else send_item(script_q[i].item, script_q[i].kind == ROW_TYPED, script_q[i].result);
    end

    phase = 0;
    while (rand_items < RAND_ITEMS) begin
      quiet = rand_items > RAND_ITEMS * 4 / 5;
      if (phase == 4) begin
        write_reg(bnes_pkg::REG_RADIUS, 24'hFFFFFF);
        write_reg(bnes_pkg::REG_BUDGET, 24'hFFFFFF);
        write_reg(bnes_pkg::REG_CAPACITY, 24'd64);
        random_query(DEPTH + 14, 1'b1);
      end else begin
        if (phase % 3 == 0) begin
          case ($urandom_range(0, 4))
            0: value = 0;
            1: value = 24'hFFFFFF;
            2: value = 24'($urandom_range(0, 4096));
            default: value = 24'($urandom);
          endcase
          write_reg(bnes_pkg::REG_RADIUS, value);
          case ($urandom_range(0, 4))
            0: value = 0;
            1: value = 24'hFFFFFF;
            2: value = 24'($urandom_range(0, 2000));
            default: value = 24'($urandom);
          endcase
          write_reg(bnes_pkg::REG_BUDGET, value);
          case ($urandom_range(0, 5))
            0: value = 0;
            1: value = 1;
            2: value = 64;
            3: value = 127;
            default: value = 24'($urandom_range(0, 127));
          endcase
          write_reg(bnes_pkg::REG_CAPACITY, value);
        end
        random_query($urandom_range(0, 40), 1'b0);
      end
      phase++;
    end

    settle();
    $display("%0d items after the table, %0d finishes, %0d results checked",
             rand_items, finishes, checked);
    $display("store overflow seen %0d times", overflow_hits);
    if (mismatches == 0) $display("No mismatches found");
    else $display("Mismatches found");
    $finish;
  end
endmodule

// ===== filelist.f =====
+incdir+src
src/bnes_pkg.sv
src/bnes_ram.sv
src/bnes_fifo.sv
src/bnes_front.sv
src/bnes_back.sv
src/budgeted_nearest_entity_select_unit.sv
dv/budgeted_nearest_entity_select_unit_tb.sv
